// ===== hw/rtl/cre_pkg.sv =====
// Catmull-Rom spline evaluator: shared types and fixed field widths.
// No dependencies; imported by the interfaces and all RTL modules.
`default_nettype none

package cre_pkg;

  // Operation carried by an input word.
  typedef enum logic [0:0] {
    FUNC_WRITE = 1'b0,
    FUNC_EVAL  = 1'b1
  } func_e;

  localparam int unsigned KNOT_INDEX_W = 8;
  localparam int unsigned SEGMENT_W    = 8;
  localparam int unsigned CFG_W        = 9;

  // Curve span: four knots per segment, n - 3 segments.
  localparam logic [CFG_W-1:0] MIN_KNOTS        = 9'd4;
  localparam logic [CFG_W-1:0] KNOT_COUNT_RESET = 9'd4;
  localparam logic [CFG_W-1:0] SEG_SPAN         = 9'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/cre_if.sv =====
// Valid/ready channel interfaces for the spline evaluator: input words,
// result words and the knot count write channel. Depends on cre_pkg.
`default_nettype none

interface cre_in_if
  import cre_pkg::*;
#(
  parameter int unsigned KNOT_BITS          = 16,
  parameter int unsigned POSITION_FRAC_BITS = 16
) ();
  logic                            valid;
  logic                            ready;
  func_e                           func;
  logic        [KNOT_INDEX_W-1:0]  knot_index;
  logic signed [KNOT_BITS-1:0]     knot_value;
  logic        [POSITION_FRAC_BITS:0] position;

  modport source (output valid, func, knot_index, knot_value, position, input ready);
  modport sink   (input valid, func, knot_index, knot_value, position, output ready);
endinterface

interface cre_out_if
  import cre_pkg::*;
#(
  parameter int unsigned KNOT_BITS = 16
) ();
  logic                       valid;
  logic                       ready;
  logic signed [KNOT_BITS:0]  curve_value;
  logic        [SEGMENT_W-1:0] segment;

  modport source (output valid, curve_value, segment, input ready);
  modport sink   (input valid, curve_value, segment, output ready);
endinterface

interface cre_cfg_if
  import cre_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] knot_count;

  modport source (output valid, knot_count, input ready);
  modport sink   (input valid, knot_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cre_knot_ram.sv =====
// Knot table split in four banks by index mod 4, so the four knots of a
// segment come out together in a single read. Depends on cre_pkg.
`default_nettype none

module cre_knot_ram
  import cre_pkg::*;
#(
  parameter int unsigned MAX_KNOTS = 256,
  parameter int unsigned KNOT_BITS = 16,
  parameter int unsigned SEG_BITS  = 9
) (
  input  wire logic                      clk_i,
  input  wire logic                      wr_en_i,
  input  wire logic [KNOT_INDEX_W-1:0]   wr_idx_i,
  input  wire logic [KNOT_BITS-1:0]      wr_data_i,
  input  wire logic                      rd_en_i,
  input  wire logic [SEG_BITS-1:0]       rd_seg_i,
  output      logic signed [KNOT_BITS-1:0] rd_knots_o [4]
);

  localparam int unsigned BANK_DEPTH = (MAX_KNOTS + 3) / 4;
  localparam int unsigned ADDR_W     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  logic                 wr_ok;
  logic [ADDR_W-1:0]    wr_addr;
  logic [KNOT_BITS-1:0] rd_q [4];
  logic [1:0]           rot_q;

  assign wr_ok   = wr_en_i && (32'(wr_idx_i) < MAX_KNOTS);
  assign wr_addr = ADDR_W'(wr_idx_i >> 2);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [KNOT_BITS-1:0] mem [BANK_DEPTH];
    logic [1:0]           rd_off;
    logic [SEG_BITS-1:0]  rd_sum;
    logic [ADDR_W-1:0]    rd_addr;

    // bank b holds the knot seg+rd_off of the window
    assign rd_off  = 2'(b) - rd_seg_i[1:0];
    assign rd_sum  = rd_seg_i + SEG_BITS'(rd_off);
    assign rd_addr = ADDR_W'(rd_sum >> 2);

    always_ff @(posedge clk_i) begin
      if (wr_ok && (wr_idx_i[1:0] == 2'(b))) begin
        mem[wr_addr] <= wr_data_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rd_en_i) begin
        rd_q[b] <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rot_q <= rd_seg_i[1:0];
    end
  end

  // put the banks back in knot order
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      rd_knots_o[j] = $signed(rd_q[2'(rot_q + 2'(j))]);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/catmull_rom_spline_evaluator.sv =====
// Uniform Catmull-Rom spline evaluator. Knot words (func = FUNC_WRITE) store a
// signed knot in a table of MAX_KNOTS entries; evaluate words (func = FUNC_EVAL)
// map a Q1.F position in [0,1] onto segment floor(pos*(n-3)), weight the four
// knots from there with the uniform Catmull-Rom basis and return the value
// rounded half up and saturated, plus the segment index. A position of one or
// more gives the last segment at fraction one, i.e. exactly knot n-2. The knot
// count n is the configured count clamped to [4, MAX_KNOTS]; write it only
// while the block is idle. Rate: one word per cycle while out_o.ready is high.
// The pipeline (segment multiply and banked table read, t^2, t^3, basis
// weights, four knot products, sum and round) advances only while the output
// register is free or being taken, so in_i.ready follows out_o.ready. The table
// is four single-port-read banks indexed by knot mod 4, one read each per cycle.
// Knot writes go through the same pipeline slot as the table read, so an
// evaluate always sees every write accepted before it. Reading a knot that was
// never written gives an undefined value. Write words produce no result.
`default_nettype none

module catmull_rom_spline_evaluator
  import cre_pkg::*;
#(
  parameter int unsigned MAX_KNOTS          = 256,
  parameter int unsigned KNOT_BITS          = 16,
  parameter int unsigned POSITION_FRAC_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cre_in_if.sink    in_i,
  cre_cfg_if.sink   cfg_i,
  cre_out_if.source out_o
);

  localparam int unsigned F     = POSITION_FRAC_BITS;
  localparam int unsigned PW    = F + 1;                    // position / fraction width
  localparam int unsigned NB    = $clog2(MAX_KNOTS + 1);    // knot count width
  localparam int unsigned PRODW = PW + NB;
  localparam int unsigned WB    = F + 4;                    // doubled weights, signed
  localparam int unsigned MW    = WB + KNOT_BITS;           // weight x knot
  localparam int unsigned SW    = MW + 2;                   // sum of four
  localparam int unsigned OW    = KNOT_BITS + 1;
  localparam logic [2*PW-1:0]   HALF    = (2*PW)'(2**(F-1));
  localparam logic signed [SW-1:0] ROUND_C = SW'(2**F);

  // ---------------- configuration: n - 3 ----------------
  logic [NB-1:0] nm3_q, nm3_d, n_cl;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    priority if (cfg_i.knot_count < MIN_KNOTS) begin
      n_cl = NB'(MIN_KNOTS);
    end else if (32'(cfg_i.knot_count) > MAX_KNOTS) begin
      n_cl = NB'(MAX_KNOTS);
    end else begin
      n_cl = NB'(cfg_i.knot_count);
    end
    nm3_d = n_cl - NB'(SEG_SPAN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nm3_q <= NB'(KNOT_COUNT_RESET) - NB'(SEG_SPAN);
    end else if (cfg_i.valid && cfg_i.ready) begin
      nm3_q <= nm3_d;
    end
  end

  // ---------------- pipeline advance ----------------
  logic out_vld_q;
  logic adv;

  assign adv        = !out_vld_q || out_o.ready;
  assign in_i.ready = adv;

  // stage valids
  logic a_vld_q, b_vld_q, c_vld_q, d_vld_q, e_vld_q, f_vld_q;

  // stage A: accepted word
  func_e                a_func_q;
  logic [KNOT_INDEX_W-1:0] a_idx_q;
  logic [KNOT_BITS-1:0] a_val_q;
  logic [PW-1:0]        a_pos_q;

  // stage A logic: segment and fraction
  logic [PRODW-1:0] prod;
  logic [NB:0]      seg_raw;
  logic [NB-1:0]    a_seg;
  logic [PW-1:0]    a_t;
  logic             a_eval;

  assign a_eval = a_vld_q && (a_func_q == FUNC_EVAL);

  always_comb begin
    prod    = PRODW'(a_pos_q) * PRODW'(nm3_q);
    seg_raw = prod[PRODW-1:F];
    if (seg_raw >= (NB+1)'(nm3_q)) begin
      // end of curve: last segment, fraction one
      a_seg = nm3_q - NB'(1);
      a_t   = PW'(2**F);
    end else begin
      a_seg = NB'(seg_raw);
      a_t   = {1'b0, prod[F-1:0]};
    end
  end

  logic signed [KNOT_BITS-1:0] b_k [4];

  cre_knot_ram #(
    .MAX_KNOTS (MAX_KNOTS),
    .KNOT_BITS (KNOT_BITS),
    .SEG_BITS  (NB)
  ) u_knot_ram (
    .clk_i      (clk_i),
    .wr_en_i    (adv && a_vld_q && (a_func_q == FUNC_WRITE)),
    .wr_idx_i   (a_idx_q),
    .wr_data_i  (a_val_q),
    .rd_en_i    (adv && a_eval),
    .rd_seg_i   (a_seg),
    .rd_knots_o (b_k)
  );

  // stage B: knots read, t^2
  logic [PW-1:0]   b_t_q;
  logic [NB-1:0]   b_seg_q;
  logic [2*PW-1:0] tt;
  logic [PW-1:0]   b_t2;

  assign tt   = (2*PW)'(b_t_q) * (2*PW)'(b_t_q) + HALF;
  assign b_t2 = tt[F+PW-1:F];

  // stage C: t^3
  logic [PW-1:0]   c_t_q, c_t2_q;
  logic [NB-1:0]   c_seg_q;
  logic signed [KNOT_BITS-1:0] c_k_q [4];
  logic [2*PW-1:0] ttt;
  logic [PW-1:0]   c_t3;

  assign ttt  = (2*PW)'(c_t2_q) * (2*PW)'(c_t_q) + HALF;
  assign c_t3 = ttt[F+PW-1:F];

  // stage D: basis weights (doubled, Q.F)
  logic [PW-1:0] d_t_q, d_t2_q, d_t3_q;
  logic [NB-1:0] d_seg_q;
  logic signed [KNOT_BITS-1:0] d_k_q [4];
  logic signed [WB-1:0] st, st2, st3;
  logic signed [WB-1:0] d_w [4];

  assign st  = $signed(WB'(d_t_q));
  assign st2 = $signed(WB'(d_t2_q));
  assign st3 = $signed(WB'(d_t3_q));

  always_comb begin
    d_w[0] = (st2 <<< 1) - st - st3;
    d_w[1] = $signed(WB'(2**(F+1))) - (st2 <<< 2) - st2 + (st3 <<< 1) + st3;
    d_w[2] = st + (st2 <<< 2) - (st3 <<< 1) - st3;
    d_w[3] = st3 - st2;
  end

  // stage E: weight x knot
  logic signed [WB-1:0]        e_w_q [4];
  logic signed [KNOT_BITS-1:0] e_k_q [4];
  logic [NB-1:0]               e_seg_q;
  logic signed [MW-1:0]        e_p [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      e_p[j] = MW'(e_w_q[j]) * MW'(e_k_q[j]);
    end
  end

  // stage F: sum, round half up, saturate
  logic signed [MW-1:0] f_p_q [4];
  logic [NB-1:0]        f_seg_q;
  logic signed [SW-1:0] sum, rsh;
  logic signed [OW-1:0] f_val;

  always_comb begin
    sum = SW'(f_p_q[0]) + SW'(f_p_q[1]) + SW'(f_p_q[2]) + SW'(f_p_q[3]) + ROUND_C;
    rsh = sum >>> (F + 1);
    if ((&rsh[SW-1:OW-1]) || !(|rsh[SW-1:OW-1])) begin
      f_val = OW'(rsh);
    end else if (rsh[SW-1]) begin
      f_val = {1'b1, {(OW-1){1'b0}}};
    end else begin
      f_val = {1'b0, {(OW-1){1'b1}}};
    end
  end

  // output register
  logic signed [OW-1:0]  out_val_q;
  logic [SEGMENT_W-1:0]  out_seg_q;

  assign out_o.valid       = out_vld_q;
  assign out_o.curve_value = out_val_q;
  assign out_o.segment     = out_seg_q;

  // control: stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      d_vld_q   <= 1'b0;
      e_vld_q   <= 1'b0;
      f_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q   <= in_i.valid;
      b_vld_q   <= a_eval;   // writes end at the table
      c_vld_q   <= b_vld_q;
      d_vld_q   <= c_vld_q;
      e_vld_q   <= d_vld_q;
      f_vld_q   <= e_vld_q;
      out_vld_q <= f_vld_q;
    end
  end

  // payload: no reset
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_func_q  <= in_i.func;
      a_idx_q   <= in_i.knot_index;
      a_val_q   <= in_i.knot_value;
      a_pos_q   <= in_i.position;

      b_t_q     <= a_t;
      b_seg_q   <= a_seg;

      c_t_q     <= b_t_q;
      c_t2_q    <= b_t2;
      c_seg_q   <= b_seg_q;
      c_k_q     <= b_k;

      d_t_q     <= c_t_q;
      d_t2_q    <= c_t2_q;
      d_t3_q    <= c_t3;
      d_seg_q   <= c_seg_q;
      d_k_q     <= c_k_q;

      e_w_q     <= d_w;
      e_k_q     <= d_k_q;
      e_seg_q   <= d_seg_q;

      f_p_q     <= e_p;
      f_seg_q   <= e_seg_q;

      out_val_q <= f_val;
      out_seg_q <= SEGMENT_W'(f_seg_q);
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking bench for the Catmull-Rom spline evaluator: knot and evaluate
// words under random handshake gaps, checked against an in-bench predictor.
// Depends on cre_pkg, the cre_*_if interfaces and catmull_rom_spline_evaluator.
module tb;
  import cre_pkg::*;

  localparam int unsigned TABLE_DEPTH   = 256;
  localparam int unsigned FRAC_W        = 16;
  localparam int unsigned IDLE_PCT      = 14;
  localparam int unsigned SETTLE_CYCLES = 10;   // stages A to F and output register, plus margin
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned QUIET_LIMIT   = 1000; // cycles with no handshake at all
  localparam int unsigned PHASE_WORDS   = 130;
  localparam int unsigned CALM_FIRST    = 700;  // words sent before the no-idle stretch
  localparam int unsigned CALM_LAST     = 1000;

  // What the driver does with one queue entry.
  typedef enum logic [1:0] {
    ACT_WORD,   // present an input word
    ACT_COUNT,  // write knot_count
    ACT_DRAIN   // wait until every expected point is out, then settle
  } act_e;

  typedef struct {
    act_e                     act;
    func_e                    func;
    logic [KNOT_INDEX_W-1:0]  idx;
    logic signed [15:0]       val;
    logic [FRAC_W:0]          pos;
    logic [CFG_W-1:0]         count;
  } stim_t;

  typedef struct {
    logic signed [16:0]     curve;
    logic [SEGMENT_W-1:0]   seg;
  } point_t;

  logic clk = 1'b0;
  logic rst_n;

  cre_in_if  in_if ();
  cre_out_if out_if ();
  cre_cfg_if cfg_if ();

  catmull_rom_spline_evaluator u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stimulus plan, filled at time 0 and drained by the driver.
  stim_t       stim_q [$];
  logic        gen_written [TABLE_DEPTH];
  int unsigned gen_knots;  // effective knot count the plan is built against
  int unsigned phase_counts [13] = '{4, 256, 5, 6, 511, 0, 3, 7, 33, 128, 255, 257, 100};

  // Predictor state: a shadow of the knot table and the count register.
  logic signed [15:0] knot_mem [TABLE_DEPTH];
  logic [CFG_W-1:0]   model_count = KNOT_COUNT_RESET;
  point_t             pending_points [$];

  // Handshake bookkeeping.
  logic        in_took = 1'b0;
  logic        cfg_took = 1'b0;
  logic        next_in, next_cfg, calm;
  logic        draining = 1'b0;
  logic        stim_done = 1'b0;
  int unsigned settle_left = 0;
  int unsigned sent = 0;
  int unsigned quiet = 0;
  int unsigned mismatches = 0;
  stim_t       cur;
  point_t      want, got;

  // Expected point for one evaluate word, from the shadow table and count.
  // Weights are doubled Q.16 Catmull-Rom basis values; the final shift by
  // 17 removes both the Q.16 scale and the factor of two, rounding half up.
  function automatic point_t spline_point(input logic [FRAC_W:0] pos);
    point_t pt;
    longint n, prod, seg, t, t2, t3, sum, r;
    longint w [4];
    n = longint'(model_count);
    if (n < 4) n = 4;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    prod = longint'(pos) * (n - 3);
    seg  = prod >>> FRAC_W;
    t    = prod & ((longint'(1) << FRAC_W) - 1);
    // End of curve: pin to the last segment at fraction one.
    if (seg >= n - 3) begin
      seg = n - 4;
      t   = longint'(1) << FRAC_W;
    end
    t2 = (t * t + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W;
    t3 = (t2 * t + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W;
    w[0] = -t + 2 * t2 - t3;
    w[1] = 2 * (longint'(1) << FRAC_W) - 5 * t2 + 3 * t3;
    w[2] = t + 4 * t2 - 3 * t3;
    w[3] = -t2 + t3;
    sum = 0;
    for (int j = 0; j < 4; j++) sum += w[j] * longint'(knot_mem[seg + j]);
    r = (sum + (longint'(1) << FRAC_W)) >>> (FRAC_W + 1);
    if (r > 65535) r = 65535;
    if (r < -65536) r = -65536;
    pt.curve = r[16:0];
    pt.seg   = seg[SEGMENT_W-1:0];
    return pt;
  endfunction

  function automatic logic signed [15:0] pick_knot();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Positions favor the ends of the curve and the segment boundaries.
  function automatic logic [FRAC_W:0] pick_position(input int unsigned n);
    longint p;
    longint s;
    case ($urandom_range(9))
      0: p = 0;
      1: p = 65536;
      2: p = 65535 - $urandom_range(3);
      3, 4: begin
        // first position that lands in segment s, jittered by one
        s = $urandom_range(n - 4);
        p = (s * 65536 + n - 4) / (n - 3) + $urandom_range(2) - 1;
      end
      default: p = $urandom_range(65536);
    endcase
    if (p < 0) p = 0;
    if (p > 65536) p = 65536;
    return p[FRAC_W:0];
  endfunction

  task automatic add_knot(input logic [KNOT_INDEX_W-1:0] idx, input logic signed [15:0] val);
    stim_t s;
    s.act   = ACT_WORD;
    s.func  = FUNC_WRITE;
    s.idx   = idx;
    s.val   = val;
    s.pos   = 17'($urandom);  // don't-care on a write
    s.count = '0;
    stim_q.insert(stim_q.size(), s);
    gen_written[idx] = 1'b1;
  endtask

  task automatic add_eval(input logic [FRAC_W:0] pos);
    stim_t s;
    s.act   = ACT_WORD;
    s.func  = FUNC_EVAL;
    s.idx   = 8'($urandom);   // don't-care on an evaluate
    s.val   = 16'($urandom);
    s.pos   = pos;
    s.count = '0;
    stim_q.insert(stim_q.size(), s);
  endtask

  // Drain, write the count, then make sure every knot in use has been written
  // so that no evaluate ever reads an empty table entry.
  task automatic add_count(input int unsigned c);
    stim_t s;
    s.act   = ACT_DRAIN;
    s.func  = FUNC_WRITE;
    s.idx   = '0;
    s.val   = '0;
    s.pos   = '0;
    s.count = c[CFG_W-1:0];
    stim_q.insert(stim_q.size(), s);
    s.act = ACT_COUNT;
    stim_q.insert(stim_q.size(), s);
    gen_knots = (c < 4) ? 4 : ((c > TABLE_DEPTH) ? TABLE_DEPTH : c);
    for (int i = 0; i < gen_knots; i++) begin
      if (!gen_written[i]) add_knot(i[KNOT_INDEX_W-1:0], pick_knot());
    end
  endtask

  // Driver: all inputs change on the falling edge. A word stays up until the
  // monitor saw it taken at the previous rising edge.
  always @(negedge clk) begin
    if (rst_n) begin
      calm = (sent >= CALM_FIRST) && (sent < CALM_LAST);
      out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      next_in  = in_if.valid && !in_took;
      next_cfg = cfg_if.valid && !cfg_took;
      if (!next_in && !next_cfg) begin
        if (settle_left != 0) begin
          settle_left--;
        end else if (draining) begin
          // sender holds until every expected point has come out
          if (pending_points.size() == 0) begin
            draining    = 1'b0;
            settle_left = SETTLE_CYCLES;
          end
        end else if (stim_q.size() == 0) begin
          stim_done = 1'b1;
        end else if (stim_q[0].act == ACT_DRAIN) begin
          void'(stim_q.pop_front());
          draining = 1'b1;
        end else if (stim_q[0].act == ACT_COUNT) begin
          cur = stim_q.pop_front();
          cfg_if.knot_count <= cur.count;
          next_cfg = 1'b1;
        end else if (calm || ($urandom_range(99) >= IDLE_PCT)) begin
          cur = stim_q.pop_front();
          in_if.func       <= cur.func;
          in_if.knot_index <= cur.idx;
          in_if.knot_value <= cur.val;
          in_if.position   <= cur.pos;
          next_in = 1'b1;
          sent++;
        end
      end
      in_if.valid  <= next_in;
      cfg_if.valid <= next_cfg;
    end
  end

  // Monitor: samples on the rising edge, checks each result word against the
  // oldest expected point, then feeds accepted words into the predictor.
  always @(posedge clk) begin
    in_took  <= in_if.valid && in_if.ready;
    cfg_took <= cfg_if.valid && cfg_if.ready;
    if (!rst_n) begin
      quiet <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pending_points.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word: expected none, got curve_value %0d segment %0d",
                   $time, out_if.curve_value, out_if.segment);
        end else begin
          want = pending_points.pop_front();
          if (out_if.curve_value !== want.curve) begin
            mismatches++;
            $display("%0t: curve_value mismatch: expected %0d, got %0d",
                     $time, want.curve, out_if.curve_value);
          end
          if (out_if.segment !== want.seg) begin
            mismatches++;
            $display("%0t: segment mismatch: expected %0d, got %0d",
                     $time, want.seg, out_if.segment);
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) model_count = cfg_if.knot_count;
      if (in_if.valid && in_if.ready) begin
        if (in_if.func == FUNC_WRITE) begin
          knot_mem[in_if.knot_index] = in_if.knot_value;
        end else begin
          got = spline_point(in_if.position);
          pending_points.insert(pending_points.size(), got);
        end
      end
      // watchdog: cycles without any handshake
      if ((in_if.valid && in_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (out_if.valid && out_if.ready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    int unsigned tail;
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.func        = FUNC_WRITE;
    in_if.knot_index  = '0;
    in_if.knot_value  = '0;
    in_if.position    = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.knot_count = KNOT_COUNT_RESET;
    out_if.ready      = 1'b0;
    gen_knots         = KNOT_COUNT_RESET;
    foreach (gen_written[i]) gen_written[i] = 1'b0;

    // Directed words at the reset count of four: alternating full-scale
    // knots, the curve ends (zero and exactly one, which pins to the last
    // segment at fraction one), the midpoint and one LSB off each end.
    add_knot(8'd0, 16'sh8000);
    add_knot(8'd1, 16'sh7FFF);
    add_knot(8'd2, 16'sh7FFF);
    add_knot(8'd3, 16'sh8000);
    add_eval(17'd0);
    add_eval(17'd65536);
    add_eval(17'd32768);
    add_eval(17'd1);
    add_eval(17'd65535);
    add_eval(17'd21845);
    // inverted pattern: largest swing of the blend
    add_knot(8'd0, 16'sh7FFF);
    add_knot(8'd1, 16'sh8000);
    add_knot(8'd2, 16'sh8000);
    add_knot(8'd3, 16'sh7FFF);
    add_eval(17'd32768);
    add_eval(17'd49152);
    add_eval(17'd16384);
    // the top table entry and entry 170 with alternating bit patterns
    add_knot(8'd255, 16'sh5555);
    add_knot(8'd170, 16'shAAAA);
    add_eval(17'h0AAAA);
    add_eval(17'h05555);

    // Random phases, one knot count each, the extremes and out-of-range
    // counts among them (0 and 3 clamp to four, 257 and 511 to the table size).
    foreach (phase_counts[p]) begin
      add_count(phase_counts[p]);
      repeat (PHASE_WORDS) begin
        if ($urandom_range(99) < 30) add_knot(8'($urandom), pick_knot());
        else add_eval(pick_position(gen_knots));
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for the plan to drain and the last point to come out, then keep
    // watching the output so that any stray result word would show.
    tail = 0;
    while (tail < TAIL_CYCLES && quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (stim_done && pending_points.size() == 0) tail++;
      else tail = 0;
    end
    if (quiet < QUIET_LIMIT && mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
